>>> sv/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, format codes and channel helpers of the texel color converter.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam logic [2:0] FMT_ARGB1555 = 3'd0;
    localparam logic [2:0] FMT_RGB565   = 3'd1;
    localparam logic [2:0] FMT_ARGB4444 = 3'd2;
    localparam logic [2:0] FMT_YUV422   = 3'd3;
    localparam logic [2:0] FMT_BUMP     = 3'd4;
    localparam logic [2:0] FMT_ARGB8888 = 3'd5;

    localparam logic [7:0] CHAN_MAX  = 8'd255;
    localparam logic [7:0] CHAN_MID  = 8'd128;
    localparam logic [7:0] CHAN_ZERO = 8'd0;

    // queued request: format at accept time, texel pair flag, raw word
    typedef struct packed {
        logic [2:0]  fmt;
        logic        pair;
        logic [31:0] word;
    } t_cmd;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_texel;
    } t_texel;

    function automatic logic [7:0] widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] c);
        return {c, c[5:4]};
    endfunction

    // c * 17 for a 4-bit channel
    function automatic logic [7:0] widen4(input logic [3:0] c);
        return {c, c};
    endfunction

    function automatic logic [7:0] clamp255(input logic signed [10:0] x);
        logic [7:0] res;
        if (x < 11'sd0) begin
            res = CHAN_ZERO;
        end else if (x > 11'sd255) begin
            res = CHAN_MAX;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

endpackage

>>> sv/tcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_front
// Accepts raw words, tags them with format and texel count, queues them.
// ----------------------------------------------------------------------------
module tcc_front import tcc_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_raw_word,
    input  logic [2:0]  i_fmt,
    output logic        o_q_valid,
    output t_cmd        o_q_cmd,
    input  logic        i_q_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;
    logic            w_acc;
    logic            w_pop;
    t_cmd            w_cmd;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_mem[r_rd];
    assign w_acc     = i_push && !o_full;
    assign w_pop     = i_q_pop && o_q_valid;

    // classify: yuv words expand to two texels
    always_comb begin
        w_cmd.fmt  = i_fmt;
        w_cmd.pair = (i_fmt == FMT_YUV422);
        w_cmd.word = i_raw_word;
    end

    always_comb begin
        n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        unique case ({w_acc, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> sv/tcc_yuv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_yuv
// YUV to RGB for one texel: constant products, truncating divides, clamp.
// ----------------------------------------------------------------------------
module tcc_yuv import tcc_pkg::*; (
    input  logic [7:0] i_y,
    input  logic [7:0] i_u,
    input  logic [7:0] i_v,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic signed [8:0]  s_u;
    logic signed [8:0]  s_v;
    logic signed [10:0] s_y;
    logic signed [12:0] s_rprod;
    logic signed [12:0] s_radj;
    logic signed [12:0] s_rq;
    logic signed [14:0] s_gsum;
    logic signed [14:0] s_gadj;
    logic signed [14:0] s_gq;
    logic signed [15:0] s_bprod;
    logic signed [15:0] s_badj;
    logic signed [15:0] s_bq;
    logic signed [10:0] s_rs;
    logic signed [10:0] s_gs;
    logic signed [10:0] s_bs;

    always_comb begin
        s_u = $signed({1'b0, i_u}) - 9'sd128;
        s_v = $signed({1'b0, i_v}) - 9'sd128;
        s_y = $signed({3'b000, i_y});

        s_rprod = 13'(s_v) * 13'sd11;
        s_gsum  = 15'(s_u) * 15'sd11 + 15'(s_v) * 15'sd22;
        s_bprod = 16'(s_u) * 16'sd110;

        // bias negatives so the arithmetic shift rounds toward zero
        s_radj = s_rprod[12] ? s_rprod + 13'sd7  : s_rprod;
        s_gadj = s_gsum[14]  ? s_gsum  + 15'sd31 : s_gsum;
        s_badj = s_bprod[15] ? s_bprod + 16'sd63 : s_bprod;
        s_rq   = s_radj >>> 3;
        s_gq   = s_gadj >>> 5;
        s_bq   = s_badj >>> 6;

        s_rs = s_y + $signed(s_rq[10:0]);
        s_gs = s_y - $signed(s_gq[10:0]);
        s_bs = s_y + $signed(s_bq[10:0]);

        o_red   = clamp255(s_rs);
        o_green = clamp255(s_gs);
        o_blue  = clamp255(s_bs);
    end

endmodule

>>> sv/tcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_back
// Converts queued requests to texels into a two-entry result queue, one per cycle while it has room.
// ----------------------------------------------------------------------------
module tcc_back import tcc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_cmd   i_q_cmd,
    output logic   o_q_pop,
    input  logic   i_pop,
    output logic   o_empty,
    output t_texel o_texel
);

    t_texel      r_out_mem [2];
    logic        r_out_wr;
    logic        r_out_rd;
    logic [1:0]  r_out_cnt;
    logic [1:0]  n_out_cnt;
    logic        r_half;
    logic        w_space;
    logic        w_produce;
    logic        w_last;
    logic        w_out_pop;
    logic [15:0] w_p;
    logic [7:0]  w_y;
    logic [7:0]  w_yr;
    logic [7:0]  w_yg;
    logic [7:0]  w_yb;
    t_texel      w_texel;

    assign w_space   = (r_out_cnt != 2'd2);
    assign w_produce = i_q_valid && w_space;
    assign w_last    = !i_q_cmd.pair || r_half;
    assign o_q_pop   = w_produce && w_last;
    assign w_out_pop = i_pop && !o_empty;
    assign o_empty   = (r_out_cnt == 2'd0);
    assign o_texel   = r_out_mem[r_out_rd];
    assign w_p       = i_q_cmd.word[15:0];
    // second texel of a yuv pair takes y1
    assign w_y       = r_half ? i_q_cmd.word[31:24] : i_q_cmd.word[15:8];

    tcc_yuv u_yuv (
        .i_y     (w_y),
        .i_u     (i_q_cmd.word[7:0]),
        .i_v     (i_q_cmd.word[23:16]),
        .o_red   (w_yr),
        .o_green (w_yg),
        .o_blue  (w_yb)
    );

    always_comb begin
        w_texel.last_texel = w_last;
        unique case (i_q_cmd.fmt)
            FMT_ARGB1555: begin
                w_texel.red   = widen5(w_p[14:10]);
                w_texel.green = widen5(w_p[9:5]);
                w_texel.blue  = widen5(w_p[4:0]);
                w_texel.alpha = w_p[15] ? CHAN_MAX : CHAN_ZERO;
            end
            FMT_RGB565: begin
                w_texel.red   = widen5(w_p[15:11]);
                w_texel.green = widen6(w_p[10:5]);
                w_texel.blue  = widen5(w_p[4:0]);
                w_texel.alpha = CHAN_MAX;
            end
            FMT_ARGB4444: begin
                w_texel.red   = widen4(w_p[11:8]);
                w_texel.green = widen4(w_p[7:4]);
                w_texel.blue  = widen4(w_p[3:0]);
                w_texel.alpha = widen4(w_p[15:12]);
            end
            FMT_YUV422: begin
                w_texel.red   = w_yr;
                w_texel.green = w_yg;
                w_texel.blue  = w_yb;
                w_texel.alpha = CHAN_MAX;
            end
            FMT_BUMP: begin
                w_texel.red   = CHAN_MID;
                w_texel.green = CHAN_MID;
                w_texel.blue  = CHAN_MAX;
                w_texel.alpha = CHAN_MAX;
            end
            FMT_ARGB8888: begin
                w_texel.red   = i_q_cmd.word[23:16];
                w_texel.green = i_q_cmd.word[15:8];
                w_texel.blue  = i_q_cmd.word[7:0];
                w_texel.alpha = i_q_cmd.word[31:24];
            end
            default: begin
                w_texel.red   = CHAN_ZERO;
                w_texel.green = CHAN_ZERO;
                w_texel.blue  = CHAN_ZERO;
                w_texel.alpha = CHAN_ZERO;
            end
        endcase
    end

    always_comb begin
        unique case ({w_produce, w_out_pop})
            2'b10:   n_out_cnt = r_out_cnt + 2'd1;
            2'b01:   n_out_cnt = r_out_cnt - 2'd1;
            default: n_out_cnt = r_out_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_out_mem[r_out_wr] <= w_texel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr  <= 1'b0;
            r_out_rd  <= 1'b0;
            r_out_cnt <= 2'd0;
            r_half    <= 1'b0;
        end else begin
            if (w_produce) begin
                r_out_wr <= !r_out_wr;
                r_half   <= i_q_cmd.pair && !r_half;
            end
            if (w_out_pop) begin
                r_out_rd <= !r_out_rd;
            end
            r_out_cnt <= n_out_cnt;
        end
    end

    // pending second texel only while its yuv request heads the queue
    a_half_on_yuv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (i_q_valid && i_q_cmd.fmt == FMT_YUV422))
        else $error("second-texel flag without a yuv request");

    a_out_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt != 2'd3)
        else $error("result queue overflow");

    a_pop_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("request queue popped while empty");

    a_pair_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_produce && i_q_cmd.pair && !r_half) |=> (r_half && !o_q_pop) || w_produce)
        else $error("yuv request left before its second texel");

endmodule

>>> sv/texel_color_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_color_converter
// Raw texture or palette words in, RGBA8888 texels out.
// ----------------------------------------------------------------------------
// Each accepted raw word is tagged with the current pixel_format and goes into
// a small request queue (QUEUE_DEPTH entries). The conversion stage takes the
// oldest request and, while the result queue has space, writes one texel per
// cycle into a two-entry result queue: 16-bit formats, bump map, ARGB8888 and
// the unused codes give one texel per word, so one word per cycle is sustained;
// a YUV422 word gives two texels and holds its request until its second texel
// is written, so a stream of YUV words runs slower. The single texel-per-cycle
// conversion stage sets the word rate. A word is registered in the request
// queue and its texel in the result queue before a result shows on the ports.
// push sees full only when the request queue is full, and the result side may
// stall freely without losing requests. last_texel marks the final texel of
// each word. pixel_format is to be written only while the block is idle.
// ----------------------------------------------------------------------------
module texel_color_converter import tcc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_raw_word,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_last_texel
);

    localparam logic REG_PIXEL_FORMAT = 1'b0;

    logic [2:0] r_pixel_format;
    logic       w_cfg_wr;
    logic       w_q_valid;
    t_cmd       w_q_cmd;
    logic       w_q_pop;
    t_texel     w_texel;

    // configuration: one register at byte address 0, word aligned decode
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_PIXEL_FORMAT) ? {29'd0, r_pixel_format} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= FMT_ARGB1555;
        end else if (w_cfg_wr && paddr[2] == REG_PIXEL_FORMAT) begin
            r_pixel_format <= pwdata[2:0];
        end
    end

    // front: accept and classify requests
    tcc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_raw_word (i_raw_word),
        .i_fmt      (r_pixel_format),
        .o_q_valid  (w_q_valid),
        .o_q_cmd    (w_q_cmd),
        .i_q_pop    (w_q_pop)
    );

    // back: convert to texels and hold results
    tcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_texel   (w_texel)
    );

    assign o_red        = w_texel.red;
    assign o_green      = w_texel.green;
    assign o_blue       = w_texel.blue;
    assign o_alpha      = w_texel.alpha;
    assign o_last_texel = w_texel.last_texel;

endmodule

>>> verif/tb_texel_color_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_texel_color_converter
// Self-checking bench for the texel color converter.
// ----------------------------------------------------------------------------
// Raw words go in through the push/full queue port. Every accepted request is
// expanded here into the texels the block should give, and each popped texel
// is checked field by field against the oldest one waiting. pixel_format is
// written through the APB port only while nothing is in flight, then read
// back. A short directed table covers the format extremes, the bump map, the
// unused codes, the ignored high half of 16-bit words, YUV clamping and
// truncation, and a write to an unmapped register. Random phases then sweep
// every format with random idle bursts on both sides, one long pop hold-off
// that fills the block, and a last phase at full rate.
// ----------------------------------------------------------------------------
module tb_texel_color_converter import tcc_pkg::*;;

    // unused format codes have no name in the package
    localparam logic [2:0] FMT_UNUSED6 = 3'd6;
    localparam logic [2:0] FMT_UNUSED7 = 3'd7;

    // register map: pixel_format is register 0, the next word is unmapped
    localparam int         REG_PIXEL_FORMAT  = 0;
    localparam logic [2:0] ADDR_PIXEL_FORMAT = 3'(4 * REG_PIXEL_FORMAT);
    localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;

    localparam int DRAIN_CYCLES  = 4;       // extra wait after the last owed texel pops
    localparam int LONG_HOLD     = 80;      // pop hold-off for back-pressure
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_ITEMS   = 50;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int NUM_DIRECTED  = 22;
    localparam int MAX_REPORTS   = 10;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push    = 1'b0;
    logic        full;
    logic [31:0] i_raw_word = '0;
    logic        empty;
    logic        pop     = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic        o_last_texel;

    texel_color_converter i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .i_raw_word   (i_raw_word),
        .empty        (empty),
        .pop          (pop),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_last_texel (o_last_texel)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // texels still owed by the block, oldest first
    t_texel pending_texels [$];
    // bench copy of pixel_format
    logic [2:0] cur_format = FMT_ARGB1555;

    int  err_cnt       = 0;
    int  mismatch_cnt  = 0;
    int  cycle_cnt     = 0;
    bit  src_idle_en   = 1'b1;
    bit  sink_idle_en  = 1'b1;
    bit  long_hold_req = 1'b0;

    // one directed request: format to run under, the word, and optionally
    // the single texel it must give
    typedef struct {
        logic [2:0]  fmt;
        bit          noise_wr;   // write the unmapped register first
        logic [31:0] word;
        bit          typed;
        t_texel      tex;
    } t_dir_row;

    t_dir_row directed_rows [NUM_DIRECTED];

    function automatic t_texel one_texel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] a);
        t_texel t;
        t.red        = r;
        t.green      = g;
        t.blue       = b;
        t.alpha      = a;
        t.last_texel = 1'b1;
        return t;
    endfunction

    function automatic logic [7:0] sat8(input int x);
        if (x < 0) begin
            return 8'd0;
        end else if (x > 255) begin
            return 8'd255;
        end
        return 8'(x);
    endfunction

    // bit-replicating widening of 5- and 6-bit channels
    function automatic logic [7:0] grow5(input int c);
        return 8'(((c << 3) | (c >> 2)) & 'hFF);
    endfunction

    function automatic logic [7:0] grow6(input int c);
        return 8'(((c << 2) | (c >> 4)) & 'hFF);
    endfunction

    // yuv to rgb for one luma sample; int division truncates toward zero
    function automatic t_texel yuv_texel(input int y, input int u, input int v,
                                         input logic lst);
        t_texel t;
        t.red        = sat8(y + (v * 11) / 8);
        t.green      = sat8(y - (u * 11 + v * 22) / 32);
        t.blue       = sat8(y + (u * 110) / 64);
        t.alpha      = 8'd255;
        t.last_texel = lst;
        return t;
    endfunction

    // append the texels one raw word converts to under the given format
    function automatic void expand_texels(input logic [2:0] fmt, input logic [31:0] w);
        int     p;
        int     u;
        int     v;
        t_texel t;
        p = int'(w[15:0]);
        case (fmt)
            FMT_ARGB1555: begin
                t = one_texel(grow5((p >> 10) & 'h1F), grow5((p >> 5) & 'h1F),
                              grow5(p & 'h1F), w[15] ? 8'd255 : 8'd0);
                pending_texels.push_back(t);
            end
            FMT_RGB565: begin
                t = one_texel(grow5((p >> 11) & 'h1F), grow6((p >> 5) & 'h3F),
                              grow5(p & 'h1F), 8'd255);
                pending_texels.push_back(t);
            end
            FMT_ARGB4444: begin
                t = one_texel(8'(((p >> 8) & 'hF) * 17), 8'(((p >> 4) & 'hF) * 17),
                              8'((p & 'hF) * 17), 8'(((p >> 12) & 'hF) * 17));
                pending_texels.push_back(t);
            end
            FMT_YUV422: begin
                // bytes low to high: u, y0, v, y1; both texels share the chroma
                u = int'(w[7:0]) - 128;
                v = int'(w[23:16]) - 128;
                pending_texels.push_back(yuv_texel(int'(w[15:8]), u, v, 1'b0));
                pending_texels.push_back(yuv_texel(int'(w[31:24]), u, v, 1'b1));
            end
            FMT_BUMP: begin
                pending_texels.push_back(one_texel(8'd128, 8'd128, 8'd255, 8'd255));
            end
            FMT_ARGB8888: begin
                pending_texels.push_back(one_texel(w[23:16], w[15:8], w[7:0], w[31:24]));
            end
            default: begin
                pending_texels.push_back(one_texel(8'd0, 8'd0, 8'd0, 8'd0));
            end
        endcase
    endfunction

    // random word, often built from corner bytes so clamps and sign changes hit
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 4; i++) begin
                case ($urandom_range(0, 4))
                    0: w[8*i +: 8] = 8'h00;
                    1: w[8*i +: 8] = 8'hFF;
                    2: w[8*i +: 8] = 8'h80;
                    3: w[8*i +: 8] = 8'h7F;
                    default: w[8*i +: 8] = 8'($urandom);
                endcase
            end
        end
        return w;
    endfunction

    // --------------------------------------------------------------------
    // apb access: setup cycle, access cycle, done at the edge with pready
    // --------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // only register 0 exists, anything else is dropped
        if (int'(addr) / 4 == REG_PIXEL_FORMAT) begin
            cur_format = data[2:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read pixel_format back and compare with the bench copy
    task automatic check_format_reg();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PIXEL_FORMAT;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {29'd0, cur_format}) begin
            err_cnt++;
            if (mismatch_cnt < MAX_REPORTS) begin
                $display("pixel_format readback: expected %0d, got %0h",
                         cur_format, prdata);
            end
            mismatch_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // --------------------------------------------------------------------
    // request side: optional idle burst, then hold push until accepted
    // --------------------------------------------------------------------
    task automatic send_word(input logic [31:0] w, input bit typed, input t_texel tex);
        int gap;
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push       <= 1'b1;
        i_raw_word <= w;
        do @(posedge i_clk); while (full);
        // accepted at this edge
        if (typed) begin
            pending_texels.push_back(tex);
        end else begin
            expand_texels(cur_format, w);
        end
    endtask

    // stop pushing and let every owed texel come out
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_texels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_format(input logic [2:0] fmt);
        logic [31:0] data;
        data      = $urandom;
        data[2:0] = fmt;
        wait_idle();
        apb_write(ADDR_PIXEL_FORMAT, data);
        check_format_reg();
    endtask

    // --------------------------------------------------------------------
    // result side: pop with random hold-off bursts, plus one long hold
    // that is counted down here while the sender keeps pushing
    // --------------------------------------------------------------------
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
            end else if (long_hold_req) begin
                hold_cnt      = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                hold_cnt = $urandom_range(1, 10);
            end
            pop <= (hold_cnt == 0);
        end
    end

    // texel checker: each popped texel against the oldest owed one
    always @(posedge i_clk) begin
        t_texel want;
        if (i_rst_n && pop && !empty) begin
            if (pending_texels.size() == 0) begin
                err_cnt++;
                if (mismatch_cnt < MAX_REPORTS) begin
                    $display("unexpected texel r=%0d g=%0d b=%0d a=%0d last=%0b",
                             o_red, o_green, o_blue, o_alpha, o_last_texel);
                end
                mismatch_cnt++;
            end else begin
                want = pending_texels.pop_front();
                if (o_red !== want.red || o_green !== want.green ||
                    o_blue !== want.blue || o_alpha !== want.alpha ||
                    o_last_texel !== want.last_texel) begin
                    err_cnt++;
                    if (mismatch_cnt < MAX_REPORTS) begin
                        $display("texel mismatch: expected r=%0d g=%0d b=%0d a=%0d last=%0b",
                                 want.red, want.green, want.blue, want.alpha,
                                 want.last_texel);
                        $display("                got      r=%0d g=%0d b=%0d a=%0d last=%0b",
                                 o_red, o_green, o_blue, o_alpha, o_last_texel);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------
    initial begin
        t_texel      no_tex;
        logic [2:0]  fmt;
        int          rot;

        no_tex = one_texel(8'd0, 8'd0, 8'd0, 8'd0);

        // directed table; rows without a typed texel go through the predictor
        directed_rows = '{
            // argb1555 from reset: zero, all ones, high half ignored
            '{FMT_ARGB1555, 1'b0, 32'h0000_0000, 1'b1,
              one_texel(8'd0, 8'd0, 8'd0, 8'd0)},
            '{FMT_ARGB1555, 1'b0, 32'h0000_FFFF, 1'b1,
              one_texel(8'd255, 8'd255, 8'd255, 8'd255)},
            '{FMT_ARGB1555, 1'b0, 32'hFFFF_0000, 1'b1,
              one_texel(8'd0, 8'd0, 8'd0, 8'd0)},
            // rgb565: alpha always opaque
            '{FMT_RGB565,   1'b0, 32'hFFFF_0000, 1'b1,
              one_texel(8'd0, 8'd0, 8'd0, 8'd255)},
            '{FMT_RGB565,   1'b0, 32'h0000_FFFF, 1'b1,
              one_texel(8'd255, 8'd255, 8'd255, 8'd255)},
            '{FMT_RGB565,   1'b0, 32'h0000_F800, 1'b1,
              one_texel(8'd255, 8'd0, 8'd0, 8'd255)},
            // argb4444
            '{FMT_ARGB4444, 1'b0, 32'h0000_FFFF, 1'b1,
              one_texel(8'd255, 8'd255, 8'd255, 8'd255)},
            '{FMT_ARGB4444, 1'b0, 32'hFFFF_0000, 1'b1,
              one_texel(8'd0, 8'd0, 8'd0, 8'd0)},
            '{FMT_ARGB4444, 1'b0, 32'h0000_1234, 1'b0, no_tex},
            // yuv422: neutral chroma, all zero, all ones, clamps both ways,
            // and small negative offsets where truncation differs from floor
            '{FMT_YUV422,   1'b0, 32'hFF80_0080, 1'b0, no_tex},
            '{FMT_YUV422,   1'b0, 32'h0000_0000, 1'b0, no_tex},
            '{FMT_YUV422,   1'b0, 32'hFFFF_FFFF, 1'b0, no_tex},
            '{FMT_YUV422,   1'b0, 32'h00FF_00FF, 1'b0, no_tex},
            '{FMT_YUV422,   1'b0, 32'hFF00_FF00, 1'b0, no_tex},
            '{FMT_YUV422,   1'b0, 32'h407F_407F, 1'b0, no_tex},
            // bump map ignores the word
            '{FMT_BUMP,     1'b0, 32'h0000_0000, 1'b1,
              one_texel(8'd128, 8'd128, 8'd255, 8'd255)},
            '{FMT_BUMP,     1'b0, 32'hFFFF_FFFF, 1'b1,
              one_texel(8'd128, 8'd128, 8'd255, 8'd255)},
            // argb8888 reorder; unmapped register write must not change it
            '{FMT_ARGB8888, 1'b0, 32'hFFFF_FFFF, 1'b1,
              one_texel(8'd255, 8'd255, 8'd255, 8'd255)},
            '{FMT_ARGB8888, 1'b0, 32'h1122_3344, 1'b1,
              one_texel(8'h22, 8'h33, 8'h44, 8'h11)},
            '{FMT_ARGB8888, 1'b1, 32'hA5C3_0F96, 1'b0, no_tex},
            // unused codes give a zero texel
            '{FMT_UNUSED6,  1'b0, 32'hFFFF_FFFF, 1'b1,
              one_texel(8'd0, 8'd0, 8'd0, 8'd0)},
            '{FMT_UNUSED7,  1'b0, 32'hFFFF_FFFF, 1'b1,
              one_texel(8'd0, 8'd0, 8'd0, 8'd0)}
        };

        // reset, released on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pixel_format must come out of reset as argb1555
        check_format_reg();

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_rows[i].fmt != cur_format) begin
                set_format(directed_rows[i].fmt);
            end
            if (directed_rows[i].noise_wr) begin
                wait_idle();
                apb_write(ADDR_UNMAPPED, {29'd0, FMT_UNUSED6});
                check_format_reg();
            end
            send_word(directed_rows[i].word, directed_rows[i].typed,
                      directed_rows[i].tex);
        end

        // random phases; the rotation visits every format code once,
        // the last phase picks one at random and runs without idling
        rot = $urandom_range(0, 7);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 8) begin
                fmt = 3'((ph * 3 + rot) % 8);
            end else begin
                fmt = 3'($urandom_range(0, 7));
            end
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                apb_write(ADDR_UNMAPPED, $urandom);
            end
            set_format(fmt);
            src_idle_en  = (ph != NUM_PHASES - 1);
            sink_idle_en = (ph != NUM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // one long pop hold-off so the request queue fills and full rises
                if (ph == 1 && n == 5) begin
                    long_hold_req = 1'b1;
                end
                send_word(pick_word(), 1'b0, no_tex);
            end
        end

        wait_idle();
        if (pending_texels.size() != 0) begin
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
sv/tcc_pkg.sv
sv/tcc_front.sv
sv/tcc_yuv.sv
sv/tcc_back.sv
sv/texel_color_converter.sv
verif/tb_texel_color_converter.sv
